/* rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_LROUND  = 8'h28;  // (
  localparam logic [CHAR_W-1:0] CH_RROUND  = 8'h29;  // )
  localparam logic [CHAR_W-1:0] CH_LSQUARE = 8'h5B;  // [
  localparam logic [CHAR_W-1:0] CH_RSQUARE = 8'h5D;  // ]
  localparam logic [CHAR_W-1:0] CH_LCURLY  = 8'h7B;  // {
  localparam logic [CHAR_W-1:0] CH_RCURLY  = 8'h7D;  // }

  // Bracket kinds
  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_CLOSE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_OPEN,
    OP_CLOSE
  } bbc_op_e;

  // Classified beat as it travels from front to back
  typedef struct packed {
    bbc_op_e           op;
    logic [KIND_W-1:0] kind;
    logic              last;
  } bbc_cmd_t;

endpackage

/* rtl/bbc_front.sv */
// ----------------------------------------------------------------------------
// bbc_front
// Accepts input beats and decodes each character into a stack command.
// ----------------------------------------------------------------------------
module bbc_front import bbc_pkg::*; (
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [CHAR_W-1:0] s_axis_tdata_i,  // [7:0] char_in
  input  logic              s_axis_tlast_i,  // last_char
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output bbc_cmd_t          cmd_o
);

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.kind = KIND_ROUND;
    cmd_o.last = s_axis_tlast_i;
    case (s_axis_tdata_i)
      CH_LROUND: begin
        cmd_o.op = OP_OPEN;  cmd_o.kind = KIND_ROUND;
      end
      CH_LSQUARE: begin
        cmd_o.op = OP_OPEN;  cmd_o.kind = KIND_SQUARE;
      end
      CH_LCURLY: begin
        cmd_o.op = OP_OPEN;  cmd_o.kind = KIND_CURLY;
      end
      CH_RROUND: begin
        cmd_o.op = OP_CLOSE; cmd_o.kind = KIND_ROUND;
      end
      CH_RSQUARE: begin
        cmd_o.op = OP_CLOSE; cmd_o.kind = KIND_SQUARE;
      end
      CH_RCURLY: begin
        cmd_o.op = OP_CLOSE; cmd_o.kind = KIND_CURLY;
      end
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase
  end

  assign cmd_valid_o     = s_axis_tvalid_i;
  assign s_axis_tready_o = cmd_ready_i;

endmodule

/* rtl/bbc_queue.sv */
// ----------------------------------------------------------------------------
// bbc_queue
// Short command FIFO between the decode front and the stack back end.
// ----------------------------------------------------------------------------
module bbc_queue import bbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_ready_o,
  input  bbc_cmd_t wr_data_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output bbc_cmd_t rd_data_o
);

  bbc_cmd_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                push, pop;

  assign wr_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/bbc_back.sv */
// ----------------------------------------------------------------------------
// bbc_back
// Executes stack commands, tracks the first error and forms the result beat.
// ----------------------------------------------------------------------------
module bbc_back import bbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  bbc_cmd_t            cmd_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic                res_balanced_o,
  output logic [STATUS_W-1:0] res_status_o
);

  logic [KIND_W-1:0]   stack_q [STACK_DEPTH];
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic [STATUS_W-1:0] err_q, err_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic                out_free, fire, push_en;
  logic [DEPTH_W-1:0]  top_pos;
  logic [STATUS_W-1:0] fin_status;

  // Output register frees up in the same cycle it is drained
  assign out_free    = !out_valid_q || res_ready_i;
  assign cmd_ready_o = !cmd_i.last || out_free;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign top_pos     = depth_q - 1'b1;

  always_comb begin
    depth_d = depth_q;
    err_d   = err_q;
    push_en = 1'b0;
    if (fire && err_q == ST_OK) begin
      case (cmd_i.op)
        OP_OPEN: begin
          if (depth_q >= DEPTH_W'(STACK_DEPTH)) begin
            err_d = ST_OVERFLOW;
          end else begin
            push_en = 1'b1;
            depth_d = depth_q + 1'b1;
          end
        end
        OP_CLOSE: begin
          if (depth_q == '0) begin
            err_d = ST_EMPTY_CLOSE;
          end else begin
            depth_d = top_pos;
            if (stack_q[top_pos[IDX_W-1:0]] != cmd_i.kind) err_d = ST_MISMATCH;
          end
        end
        default: ;
      endcase
    end

    fin_status = err_d;
    if (err_d == ST_OK && depth_d != '0) fin_status = ST_UNCLOSED;

    out_valid_d  = out_valid_q && !res_ready_i;
    out_status_d = out_status_q;
    if (fire && cmd_i.last) begin
      out_valid_d  = 1'b1;
      out_status_d = fin_status;
      depth_d      = '0;
      err_d        = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    if (push_en) begin
      stack_q[depth_q[IDX_W-1:0]] <= cmd_i.kind;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign res_status_o   = out_status_q;
  assign res_balanced_o = (out_status_q == ST_OK);

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cmd_i.last |=> depth_q == '0 && err_q == ST_OK && out_valid_q)
    else $error("state not cleared after last beat");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_ready_i |=> out_valid_q && $stable(out_status_q))
    else $error("pending result lost");

  a_sticky_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_OK && !(fire && cmd_i.last) |=> $stable(err_q) && $stable(depth_q))
    else $error("state changed after error");

endmodule

/* rtl/bracket_balance_checker_core.sv */
// ----------------------------------------------------------------------------
// bracket_balance_checker_core
// Bracket balance checker: decode front, command queue, stack back end.
//
//   Channel   Dir  tdata                         tuser  tlast
//   s_axis    in   [7:0] char_in                 -      last_char
//   m_axis    out  [0] balanced, [3:1] status    -      -
//
// One character per cycle sustained while m_axis does not stall; the stack push
// or pop and its compare are done in the back end on a flop register file.
// A result passes the queue, then the output register, after its last beat is
// taken. Reset clears depth, error and queue; no clearing pass.
// A stall on m_axis holds the back end only at a last beat; the queue
// absorbs two beats before s_axis_tready_o falls.
// ----------------------------------------------------------------------------
module bracket_balance_checker_core import bbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [CHAR_W-1:0] s_axis_tdata_i,  // [7:0] char_in
  input  logic              s_axis_tlast_i,  // last_char
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o   // [0] balanced, [3:1] status, [7:4] zero
);

  bbc_cmd_t            fr_cmd, bk_cmd;
  logic                fr_valid, fr_ready, bk_valid, bk_ready;
  logic                res_balanced;
  logic [STATUS_W-1:0] res_status;

  bbc_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .cmd_valid_o     (fr_valid),
    .cmd_ready_i     (fr_ready),
    .cmd_o           (fr_cmd)
  );

  bbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_cmd),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_cmd)
  );

  bbc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (bk_valid),
    .cmd_ready_o    (bk_ready),
    .cmd_i          (bk_cmd),
    .res_valid_o    (m_axis_tvalid_o),
    .res_ready_i    (m_axis_tready_i),
    .res_balanced_o (res_balanced),
    .res_status_o   (res_status)
  );

  assign m_axis_tdata_o = {4'b0000, res_status, res_balanced};

endmodule
